/* design/bsed_pkg.sv */
// Package for the backslash escape decoder.
// Holds the character constants, escape phase codes and the queue entry type.
// No dependencies.
package bsed_pkg;

  localparam int QDEPTH_DEF = 4;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  // Escape phase codes.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BSL  = 3'd1;
  localparam logic [2:0] PH_X0   = 3'd2;
  localparam logic [2:0] PH_X1   = 3'd3;
  localparam logic [2:0] PH_O0   = 3'd4;
  localparam logic [2:0] PH_O1   = 3'd5;
  localparam logic [2:0] PH_O2   = 3'd6;

  // One queue entry: the output words that one input word causes.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } bsed_entry_t;

  // Simple escapes: bit 8 set when the character is one.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h5C:   r = {1'b1, 8'h5C};
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h65:   r = {1'b1, 8'h1B};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0B};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/bsed_front.sv */
// Front end of the backslash escape decoder: accepts input words, runs the
// escape state machine and pushes the resulting bytes as one queue entry.
// Depends on bsed_pkg.
module bsed_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output bsed_pkg::bsed_entry_t q_wdata
);
  import bsed_pkg::*;

  logic       interp_r;
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] digit_r, digit_nxt;

  logic       accept;
  logic [7:0] c;
  logic       is_hex, is_oct;
  logic [3:0] hex_v;
  logic [2:0] oct_v;
  logic [8:0] simp;
  logic [1:0] n;
  logic [2:0][7:0] b;
  logic       fresh;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign c         = in_tdata;

  always_comb begin
    is_hex = 1'b0;
    hex_v  = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      is_hex = 1'b1;
      hex_v  = 4'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LF) begin
      is_hex = 1'b1;
      hex_v  = 4'(c - CH_LA + HEX_TEN);
    end else if (c >= CH_UA && c <= CH_UF) begin
      is_hex = 1'b1;
      hex_v  = 4'(c - CH_UA + HEX_TEN);
    end
    is_oct = (c >= CH_ZERO) && (c <= CH_SEVEN);
    oct_v  = c[2:0];
    simp   = simple_escape(c);
  end

  always_comb begin
    phase_nxt = phase_r;
    digit_nxt = digit_r;
    n         = 2'd0;
    b         = '0;
    fresh     = 1'b0;
    if (!interp_r) begin
      phase_nxt = PH_IDLE;
      if (!in_tuser) begin
        b[0] = c;
        n    = 2'd1;
      end
    end else if (in_tuser) begin
      // End of string flushes whatever the pending escape has collected.
      phase_nxt = PH_IDLE;
      unique case (phase_r)
        PH_BSL: begin
          b[0] = CH_BSL;
          n    = 2'd1;
        end
        PH_X0: begin
          b[0] = CH_BSL;
          b[1] = CH_X;
          n    = 2'd2;
        end
        PH_O0: begin
          b[0] = CH_BSL;
          b[1] = CH_ZERO;
          n    = 2'd2;
        end
        PH_X1, PH_O1, PH_O2: begin
          b[0] = digit_r;
          n    = 2'd1;
        end
        default: ;
      endcase
    end else begin
      unique case (phase_r)
        PH_BSL: begin
          if (simp[8]) begin
            b[0]      = simp[7:0];
            n         = 2'd1;
            phase_nxt = PH_IDLE;
          end else if (c == CH_X) begin
            phase_nxt = PH_X0;
          end else if (c == CH_ZERO) begin
            phase_nxt = PH_O0;
          end else begin
            b[0]  = CH_BSL;
            n     = 2'd1;
            fresh = 1'b1;
          end
        end
        PH_X0: begin
          if (is_hex) begin
            digit_nxt = {4'd0, hex_v};
            phase_nxt = PH_X1;
          end else begin
            b[0]  = CH_BSL;
            b[1]  = CH_X;
            n     = 2'd2;
            fresh = 1'b1;
          end
        end
        PH_X1: begin
          if (is_hex) begin
            b[0]      = {digit_r[3:0], hex_v};
            n         = 2'd1;
            phase_nxt = PH_IDLE;
          end else begin
            b[0]  = digit_r;
            n     = 2'd1;
            fresh = 1'b1;
          end
        end
        PH_O0: begin
          if (is_oct) begin
            digit_nxt = {5'd0, oct_v};
            phase_nxt = PH_O1;
          end else begin
            b[0]  = CH_BSL;
            b[1]  = CH_ZERO;
            n     = 2'd2;
            fresh = 1'b1;
          end
        end
        PH_O1: begin
          if (is_oct) begin
            digit_nxt = {digit_r[4:0], oct_v};
            phase_nxt = PH_O2;
          end else begin
            b[0]  = digit_r;
            n     = 2'd1;
            fresh = 1'b1;
          end
        end
        PH_O2: begin
          // The third octal digit wraps the value modulo 256.
          if (is_oct) begin
            b[0]      = {digit_r[4:0], oct_v};
            n         = 2'd1;
            phase_nxt = PH_IDLE;
          end else begin
            b[0]  = digit_r;
            n     = 2'd1;
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
      // The character that broke an escape is handled as if nothing were pending.
      if (fresh) begin
        if (c == CH_BSL) begin
          phase_nxt = PH_BSL;
        end else begin
          phase_nxt = PH_IDLE;
          b[n]      = c;
          n         = n + 2'd1;
        end
      end
    end
  end

  assign q_push        = accept && (n != 2'd0);
  assign q_wdata.cnt   = n;
  assign q_wdata.bytes = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_r <= 1'b0;
      phase_r  <= PH_IDLE;
      digit_r  <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      interp_r <= cfg_data;
      phase_r  <= PH_IDLE;
    end else if (accept) begin
      phase_r <= phase_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

/* design/bsed_queue.sv */
// Short queue between front and back end of the escape decoder.
// Each entry holds the one to three bytes caused by one input word.
// Depends on bsed_pkg.
module bsed_queue #(
  parameter int DEPTH = bsed_pkg::QDEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bsed_pkg::bsed_entry_t wdata,
  input  logic                  pop,
  output logic                  full,
  output logic                  empty,
  output bsed_pkg::bsed_entry_t head
);
  import bsed_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bsed_entry_t     mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

/* design/bsed_back.sv */
// Back end of the escape decoder: sends the head entry's bytes, one word
// per cycle while out_tready is high; tlast marks the entry's final byte.
// Depends on bsed_pkg.
module bsed_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  bsed_pkg::bsed_entry_t q_head,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast
);
  import bsed_pkg::*;

  logic [1:0] sel_r;

  assign out_tvalid = !q_empty;
  assign out_tdata  = q_head.bytes[sel_r];
  assign out_tlast  = (sel_r == q_head.cnt - 2'd1);
  assign q_pop      = out_tvalid && out_tready && out_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 2'd0;
    end else if (out_tvalid && out_tready) begin
      sel_r <= out_tlast ? 2'd0 : sel_r + 2'd1;
    end
  end

endmodule

/* design/backslash_escape_decoder_top.sv */
// Backslash escape decoder, top level in the manner of echo -e.
// Instantiates bsed_front, bsed_queue and bsed_back; depends on bsed_pkg.
//
// Usage:
// The in_ channel takes one character word per cycle while in_tready is high;
// in_tdata is the byte, in_tuser is 0 for a character and 1 for end of
// string, which flushes a pending escape. The out_ channel gives decoded
// bytes; out_tlast marks the final byte caused by one input word. An input
// word causes zero to three output words.
// The cfg_ channel writes interpret_escapes (cfg_data); a write drops any
// pending escape. Write it only while the block is idle.
// Bytes are registered in the queue and go out once earlier entries are sent.
// Throughput: one input word per cycle while the output drains one word per
// cycle; the back end sends one word per cycle, so a word with two or three
// results holds it till the last is sent. The queue of QDEPTH entries absorbs
// these bursts and output stalls; in_tready drops only when it is full.
// Reset (rst_n low, synchronous) empties the queue, clears the escape state
// and disables escape decoding.
module backslash_escape_decoder_top #(
  parameter int QDEPTH = bsed_pkg::QDEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic       in_tuser,   // [0] kind
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] byte_out
  output logic       out_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import bsed_pkg::*;

  bsed_entry_t q_wdata, q_head;
  logic        q_push, q_pop, q_full, q_empty;

  bsed_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  bsed_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  bsed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* design/bsed_checker.sv */
// Port-level checks for the backslash escape decoder.
// Bound to backslash_escape_decoder_top; uses only its ports.
module bsed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Reset leaves nothing to send.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  // Input backpressure only comes from a full queue, which has words to send.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with nothing to send");

  // A burst that is not finished keeps going.
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("burst ended without tlast");

endmodule

bind backslash_escape_decoder_top bsed_checker u_bsed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* tb/escape_check_pkg.sv */
// Scoreboard for the backslash escape decoder testbench.
// Tracks the decoder state on its own and holds the decoded bytes still to come.
// Depends on bsed_pkg for the character and escape phase constants.
package escape_check_pkg;

  import bsed_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } decoded_byte_t;

  class escape_scoreboard;

    bit            interpret;
    logic [2:0]    phase;
    logic [7:0]    digits;
    decoded_byte_t awaited[$];
    int            fail_count;
    int            words_checked;

    function new();
      interpret     = 1'b0;
      phase         = PH_IDLE;
      digits        = 8'd0;
      fail_count    = 0;
      words_checked = 0;
    endfunction

    // A register write drops whatever escape was in progress.
    function void set_mode(bit en);
      interpret = en;
      phase     = PH_IDLE;
    endfunction

    function void report(string msg);
      if (fail_count < 10) $display("ERROR: %s", msg);
      fail_count++;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void push(logic [7:0] b);
      decoded_byte_t e;
      e.value = b;
      e.last  = 1'b0;
      awaited.push_back(e);
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
      if (c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + int'(HEX_TEN);
      if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + int'(HEX_TEN);
      return -1;
    endfunction

    function int oct_digit(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_SEVEN) return int'(c) - int'(CH_ZERO);
      return -1;
    endfunction

    // The character that broke an escape, or one seen while idle.
    function void restart(logic [7:0] c);
      phase = PH_IDLE;
      if (c == CH_BSL) phase = PH_BSL;
      else push(c);
    endfunction

    function void decode_char(logic [7:0] c);
      int v;
      case (phase)
        PH_BSL: begin
          case (c)
            CH_BSL:  v = 'h5C;
            "a":     v = 'h07;
            "b":     v = 'h08;
            "e":     v = 'h1B;
            "f":     v = 'h0C;
            "n":     v = 'h0A;
            "r":     v = 'h0D;
            "t":     v = 'h09;
            "v":     v = 'h0B;
            default: v = -1;
          endcase
          if (v >= 0) begin
            push(8'(v));
            phase = PH_IDLE;
            return;
          end
          if (c == CH_X) begin
            phase = PH_X0;
            return;
          end
          if (c == CH_ZERO) begin
            phase = PH_O0;
            return;
          end
          push(CH_BSL);
        end
        PH_X0: begin
          v = hex_digit(c);
          if (v >= 0) begin
            digits = 8'(v);
            phase  = PH_X1;
            return;
          end
          push(CH_BSL);
          push(CH_X);
        end
        PH_X1: begin
          v = hex_digit(c);
          if (v >= 0) begin
            push(8'(int'(digits) * 16 + v));
            phase = PH_IDLE;
            return;
          end
          push(digits);
        end
        PH_O0: begin
          v = oct_digit(c);
          if (v >= 0) begin
            digits = 8'(v);
            phase  = PH_O1;
            return;
          end
          push(CH_BSL);
          push(CH_ZERO);
        end
        PH_O1: begin
          v = oct_digit(c);
          if (v >= 0) begin
            digits = 8'(int'(digits) * 8 + v);
            phase  = PH_O2;
            return;
          end
          push(digits);
        end
        PH_O2: begin
          v = oct_digit(c);
          if (v >= 0) begin
            // The third octal digit may overflow a byte; it wraps.
            push(8'(int'(digits) * 8 + v));
            phase = PH_IDLE;
            return;
          end
          push(digits);
        end
        default: ;
      endcase
      restart(c);
    endfunction

    function void flush();
      case (phase)
        PH_BSL: push(CH_BSL);
        PH_X0: begin
          push(CH_BSL);
          push(CH_X);
        end
        PH_O0: begin
          push(CH_BSL);
          push(CH_ZERO);
        end
        PH_X1, PH_O1, PH_O2: push(digits);
        default: ;
      endcase
      phase = PH_IDLE;
    endfunction

    function void note_input(bit kind, logic [7:0] c);
      int            held;
      decoded_byte_t e;
      held = awaited.size();
      if (!interpret) begin
        phase = PH_IDLE;
        if (!kind) push(c);
      end else if (kind) begin
        flush();
      end else begin
        decode_char(c);
      end
      if (awaited.size() > held) begin
        e      = awaited.pop_back();
        e.last = 1'b1;
        awaited.push_back(e);
      end
    endfunction

    function void check_output(logic [7:0] b, logic last);
      decoded_byte_t e;
      words_checked++;
      if (awaited.size() == 0) begin
        report($sformatf("output word %0d not expected: byte %h last %b",
                         words_checked, b, last));
        return;
      end
      e = awaited.pop_front();
      if (b !== e.value)
        report($sformatf("output word %0d byte: expected %h got %h",
                         words_checked, e.value, b));
      if (last !== e.last)
        report($sformatf("output word %0d last: expected %b got %b",
                         words_checked, e.last, last));
    endfunction

    function void close_out();
      decoded_byte_t e;
      while (awaited.size() != 0) begin
        e = awaited.pop_front();
        report($sformatf("byte %h last %b never came out", e.value, e.last));
      end
    endfunction

  endclass

endpackage

/* tb/tb_top.sv */
// Top of the backslash escape decoder testbench: clock, reset, drivers and checks.
// Depends on bsed_pkg, escape_check_pkg and backslash_escape_decoder_top.
module tb_top;

  import bsed_pkg::*;
  import escape_check_pkg::*;

  localparam int    IDLE_LIMIT    = 2000;
  localparam int    SETTLE_CYCLES = 4;
  localparam int    LONG_HOLD     = 80;
  localparam string HEX_CHARS     = "0123456789abcdefABCDEF";
  localparam string OCT_CHARS     = "01234567";
  localparam string SIMPLE_CHARS  = "\\abefnrtv";

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  escape_scoreboard sb = new();
  bit               no_gaps;
  bit               hold_req;
  int               words_sent;
  int               idle_cycles;

  backslash_escape_decoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Handshakes are sampled right after the edge, where every input still
  // holds the value that the edge saw.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_mode(cfg_data);
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_output(out_tdata, out_tlast);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) ||
          (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stalls per word, and one long hold-off on request.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_word(bit kind, logic [7:0] c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  // The block has nothing left to deliver once every byte has come out and
  // a few cycles have passed for a word that gave no byte.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(bit en);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed escapes with random content; the next token breaks
  // any escape left short.
  task automatic send_escape_token();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_word(1'b0, 8'($urandom_range(0, 255)));
    end else if (pick < 40) begin
      send_word(1'b0, CH_BSL);
      send_word(1'b0, SIMPLE_CHARS[$urandom_range(0, SIMPLE_CHARS.len() - 1)]);
    end else if (pick < 58) begin
      send_word(1'b0, CH_BSL);
      send_word(1'b0, CH_X);
      n = $urandom_range(0, 2);
      repeat (n) send_word(1'b0, HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)]);
    end else if (pick < 76) begin
      send_word(1'b0, CH_BSL);
      send_word(1'b0, CH_ZERO);
      n = $urandom_range(0, 3);
      repeat (n) send_word(1'b0, OCT_CHARS[$urandom_range(0, OCT_CHARS.len() - 1)]);
    end else if (pick < 86) begin
      send_word(1'b1, 8'($urandom_range(0, 255)));
    end else if (pick < 94) begin
      send_word(1'b0, CH_BSL);
      send_word(1'b0, 8'($urandom_range(0, 255)));
    end else begin
      send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(bit decode, int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      if (decode)
        send_escape_token();
      else
        send_word(1'($urandom_range(0, 99) < 15), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    in_tuser   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    rst_n      = 1'b0;
    no_gaps    = 1'b0;
    hold_req   = 1'b0;
    words_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Decoding is off after reset: bytes pass, end of string gives nothing.
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, CH_BSL);
    send_word(1'b1, 8'h6E);

    write_mode(1'b1);
    send_text("\\n\\\\");
    send_text("\\xFf\\x7g");
    send_text("\\xq");
    send_text("\\0777");
    send_text("\\09");
    send_text("\\");
    send_word(1'b1, 8'h00);
    send_text("\\x");
    send_word(1'b1, 8'hFF);
    send_text("\\0");
    send_word(1'b1, 8'h00);
    // A write while an escape is open discards it without output.
    send_text("\\0");
    write_mode(1'b1);
    send_text("5");

    no_gaps = 1'b1;
    run_random(1'b1, 60);
    no_gaps = 1'b0;
    write_mode(1'b0);
    run_random(1'b0, 40);
    write_mode(1'b1);
    hold_req = 1'b1;
    run_random(1'b1, 100);
    write_mode(1'b0);
    write_mode(1'b1);
    run_random(1'b1, 50);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
design/bsed_pkg.sv
design/bsed_front.sv
design/bsed_queue.sv
design/bsed_back.sv
design/backslash_escape_decoder_top.sv
design/bsed_checker.sv
tb/escape_check_pkg.sv
tb/tb_top.sv
